// ===== rtl/core/ecacc_pkg.sv =====
// ecacc_pkg: shared types, widths and field positions of the encoder count accumulator
// used by every module under rtl/core and by the port checker; no dependencies

package ecacc_pkg;

   localparam int CHANNELS   = 2;
   localparam int COUNT_BITS = 16;
   localparam int TOTAL_BITS = 32;
   localparam int TIME_BITS  = 32;

   // req_tdata: now_ms, then one encoder count per channel
   localparam int REQ_DATA_BITS = TIME_BITS + COUNT_BITS * CHANNELS;
   localparam int REQ_RAW_LSB   = TIME_BITS;

   // rsp_tdata: deltas, totals, period_ms, fresh_sample, range_error, zero fill
   localparam int RSP_TOTAL_LSB    = COUNT_BITS * CHANNELS;
   localparam int RSP_INTERVAL_LSB = RSP_TOTAL_LSB + TOTAL_BITS * CHANNELS;
   localparam int RSP_VALID_BIT    = RSP_INTERVAL_LSB + TIME_BITS;
   localparam int RSP_ERROR_BIT    = RSP_VALID_BIT + 1;
   localparam int RSP_USED_BITS    = RSP_ERROR_BIT + 1;
   localparam int RSP_DATA_BITS    = ((RSP_USED_BITS + 7) / 8) * 8;

   typedef enum logic [0:0] {
      REQ_INIT   = 1'b0,
      REQ_UPDATE = 1'b1
   } ecacc_kind_type;

   typedef struct packed {
      ecacc_kind_type                       kind;
      logic [TIME_BITS-1:0]                 now_ms;
      logic [CHANNELS-1:0][COUNT_BITS-1:0]  enc_count;
   } ecacc_item_type;

   typedef struct packed {
      logic                                 accepted;
      logic [CHANNELS-1:0][COUNT_BITS-1:0]  delta;
      logic [CHANNELS-1:0][TOTAL_BITS-1:0]  total;
      logic [TIME_BITS-1:0]                 period_ms;
      logic                                 fresh_sample;
      logic                                 range_error;
   } ecacc_result_type;

endpackage

// ===== rtl/core/ecacc_in_stage.sv =====
// ecacc_in_stage: input register holding one request item ahead of the update logic
// depends on ecacc_pkg for the item type

module ecacc_in_stage
   import ecacc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  ecacc_item_type in_item,
   input  logic           down_ready,
   output logic           out_valid,
   output ecacc_item_type out_item
);

   logic           valid_ff, valid_in;
   ecacc_item_type item_ff;
   logic           advance;
   logic           load;

   assign advance  = valid_ff && down_ready;
   assign in_ready = !valid_ff || down_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/core/ecacc_core.sv =====
// ecacc_core: per-channel wrapped delta, running totals, interval and flags
// depends on ecacc_pkg for item and result types

module ecacc_core
   import ecacc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  ecacc_item_type   item,
   output ecacc_result_type result
);

   logic [CHANNELS-1:0][COUNT_BITS-1:0] last_raw_ff, last_raw_in;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] last_delta_ff, last_delta_in;
   logic [CHANNELS-1:0][TOTAL_BITS-1:0] total_ff, total_in;
   logic [TIME_BITS-1:0]                last_time_ff, last_time_in;
   logic [TIME_BITS-1:0]                interval_ff, interval_in;
   logic                                ready_ff, ready_in;
   logic                                valid_ff, valid_in;
   logic                                error_ff, error_in;

   logic [CHANNELS-1:0][COUNT_BITS-1:0] diff;
   logic [CHANNELS-1:0][TOTAL_BITS:0]   sum;
   logic [TIME_BITS-1:0]                elapsed;
   logic                                overflow;
   logic                                live;
   logic                                commit;

   always_comb begin
      overflow = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         // 16-bit difference read as two's complement gives the wrapped delta
         diff[c] = item.enc_count[c] - last_raw_ff[c];
         sum[c]  = {total_ff[c][TOTAL_BITS-1], total_ff[c]}
                 + {{(TOTAL_BITS + 1 - COUNT_BITS){diff[c][COUNT_BITS-1]}}, diff[c]};
         overflow = overflow | (sum[c][TOTAL_BITS] ^ sum[c][TOTAL_BITS-1]);
      end
   end

   assign elapsed = item.now_ms - last_time_ff;
   assign live    = ready_ff && (elapsed != '0);
   assign commit  = (item.kind == REQ_UPDATE) && live && !overflow;

   always_comb begin
      last_raw_in   = last_raw_ff;
      last_delta_in = last_delta_ff;
      total_in      = total_ff;
      last_time_in  = last_time_ff;
      interval_in   = interval_ff;
      ready_in      = ready_ff;
      valid_in      = valid_ff;
      error_in      = error_ff;
      unique case (item.kind)
         REQ_INIT: begin
            last_raw_in   = item.enc_count;
            last_delta_in = '0;
            total_in      = '0;
            last_time_in  = item.now_ms;
            interval_in   = '0;
            ready_in      = 1'b1;
            valid_in      = 1'b0;
            error_in      = 1'b0;
         end
         REQ_UPDATE: begin
            if (live && overflow) begin
               // all or nothing: keep counts, totals and time
               error_in = 1'b1;
               valid_in = 1'b0;
            end else if (live) begin
               last_raw_in   = item.enc_count;
               last_delta_in = diff;
               for (int c = 0; c < CHANNELS; c++) begin
                  total_in[c] = sum[c][TOTAL_BITS-1:0];
               end
               last_time_in = item.now_ms;
               interval_in  = elapsed;
               valid_in     = 1'b1;
            end
         end
         default: begin
            ready_in = ready_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff   <= '0;
         last_delta_ff <= '0;
         total_ff      <= '0;
         last_time_ff  <= '0;
         interval_ff   <= '0;
         ready_ff      <= 1'b0;
         valid_ff      <= 1'b0;
         error_ff      <= 1'b0;
      end else if (step) begin
         last_raw_ff   <= last_raw_in;
         last_delta_ff <= last_delta_in;
         total_ff      <= total_in;
         last_time_ff  <= last_time_in;
         interval_ff   <= interval_in;
         ready_ff      <= ready_in;
         valid_ff      <= valid_in;
         error_ff      <= error_in;
      end
   end

   // the result shows the state as it stands after this item
   always_comb begin
      result.accepted     = commit;
      result.delta        = last_delta_in;
      result.total        = total_in;
      result.period_ms    = interval_in;
      result.fresh_sample = valid_in;
      result.range_error  = error_in;
   end

endmodule

// ===== rtl/core/ecacc_out_stage.sv =====
// ecacc_out_stage: result register plus skid entry; input is held off only while the skid is full
// depends on ecacc_pkg for the result type

module ecacc_out_stage
   import ecacc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ecacc_result_type in_result,
   output logic             out_valid,
   input  logic             out_ready,
   output ecacc_result_type out_result
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   ecacc_result_type main_ff, skid_ff;
   logic             push;
   logic             pop;
   logic             load_main;
   logic             load_skid;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && !skid_valid_ff;
   assign pop      = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_main     = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end else begin
            load_main     = 1'b1;
            main_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && pop) begin
         main_ff <= skid_ff;
      end else if (load_main) begin
         main_ff <= in_result;
      end
      if (load_skid) begin
         skid_ff <= in_result;
      end
   end

   assign out_valid  = main_valid_ff;
   assign out_result = main_ff;

endmodule

// ===== rtl/core/encoder_count_accumulator.sv =====
// encoder_count_accumulator: top level, packs the stream ports around input stage, core and output stage
// depends on ecacc_pkg, ecacc_in_stage, ecacc_core, ecacc_out_stage
//
//   channel   direction  ports                          contents
//   req       in         req_tvalid/tready/tdata/tuser  one snapshot item: init or update
//   rsp       out        rsp_tvalid/tready/tdata/tuser  one result item per snapshot
//
// one item per cycle sustained while rsp_tready stays high; a result passes through the
// input register, then the update logic and state commit into the result register
// the delta add and 33-bit overflow check per channel sit between those two registers
// reset clears the state to not initialized and empties both stages
// a stalled rsp side fills the skid entry, then req_tready drops after one more item

module encoder_count_accumulator
   import ecacc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // now_ms, enc_count_a, enc_count_b
   input  logic [0:0]               req_tuser,  // req_type
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // delta_a, delta_b, total_a, total_b,
                                                // period_ms, fresh_sample, range_error, zeros
   output logic [0:0]               rsp_tuser   // accepted
);

   ecacc_item_type   req_item;
   ecacc_item_type   s1_item;
   logic             s1_valid;
   logic             core_ready;
   logic             step;
   ecacc_result_type core_result;
   ecacc_result_type rsp_result;

   always_comb begin
      req_item.kind   = ecacc_kind_type'(req_tuser[0]);
      req_item.now_ms = req_tdata[TIME_BITS-1:0];
      for (int c = 0; c < CHANNELS; c++) begin
         req_item.enc_count[c] = req_tdata[REQ_RAW_LSB + c*COUNT_BITS +: COUNT_BITS];
      end
   end

   ecacc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .down_ready (core_ready),
      .out_valid  (s1_valid),
      .out_item   (s1_item)
   );

   assign step = s1_valid && core_ready;

   ecacc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s1_item),
      .result (core_result)
   );

   ecacc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (step),
      .in_ready   (core_ready),
      .in_result  (core_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         rsp_tdata[c*COUNT_BITS +: COUNT_BITS]                 = rsp_result.delta[c];
         rsp_tdata[RSP_TOTAL_LSB + c*TOTAL_BITS +: TOTAL_BITS] = rsp_result.total[c];
      end
      rsp_tdata[RSP_INTERVAL_LSB +: TIME_BITS] = rsp_result.period_ms;
      rsp_tdata[RSP_VALID_BIT]                 = rsp_result.fresh_sample;
      rsp_tdata[RSP_ERROR_BIT]                 = rsp_result.range_error;
      rsp_tuser[0]                             = rsp_result.accepted;
   end

endmodule

// ===== rtl/core/ecacc_checker.sv =====
// ecacc_checker: port-level checks on the encoder count accumulator, bound to the top level
// depends on ecacc_pkg for field positions

module ecacc_checker
   import ecacc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser
);

   // nothing left over after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item present right after reset");

   // both stages empty after reset, so an item can be taken at once
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("req_tready low right after reset");

   // a committed update always leaves a fresh sample flagged
   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tdata[RSP_VALID_BIT])
      else $error("accepted item without fresh_sample");

   // no result item without an item having come in earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!req_tvalid && !rsp_tvalid) ##1 (!req_tvalid && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result item with no item taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result item changed while stalled");

endmodule

bind encoder_count_accumulator ecacc_checker u_ecacc_checker (.*);

// ===== tb/sv/encoder_count_checker.sv =====
`timescale 1ns / 1ps
// encoder_count_checker: watches the req and rsp streams of encoder_count_accumulator,
// predicts every result item from the snapshots taken and compares it field by field
// depends on ecacc_pkg

module encoder_count_checker
   import ecacc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // now_ms, enc_count_a, enc_count_b
   input  logic [0:0]               req_tuser,  // req_type
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,  // delta_a, delta_b, total_a, total_b,
                                                // period_ms, fresh_sample, range_error, zeros
   input  logic [0:0]               rsp_tuser,  // accepted
   output int                       failures,
   output int                       pending
);

   localparam int REPORT_LIMIT = 100;

   // predicted copy of the block state
   logic [CHANNELS-1:0][COUNT_BITS-1:0] held_raw;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] held_delta;
   logic [CHANNELS-1:0][TOTAL_BITS-1:0] sum_total;
   logic [TIME_BITS-1:0]                stamp_ms;
   logic [TIME_BITS-1:0]                span_ms;
   logic                                is_armed;
   logic                                is_fresh;
   logic                                is_tripped;

   ecacc_result_type expected_snapshots[$];
   int               mismatch_count = 0;

   function automatic ecacc_result_type predict_snapshot(input ecacc_item_type snap);
      ecacc_result_type                    res;
      logic [CHANNELS-1:0][COUNT_BITS-1:0] step;
      logic [CHANNELS-1:0][TOTAL_BITS-1:0] next_sum;
      logic [TOTAL_BITS:0]                 wide;
      logic [TIME_BITS-1:0]                gap_ms;
      logic                                spills;
      int                                  c;
      res    = '0;
      spills = 1'b0;
      gap_ms = snap.now_ms - stamp_ms;
      if (snap.kind == REQ_INIT) begin
         held_raw   = snap.enc_count;
         held_delta = '0;
         sum_total  = '0;
         stamp_ms   = snap.now_ms;
         span_ms    = '0;
         is_armed   = 1'b1;
         is_fresh   = 1'b0;
         is_tripped = 1'b0;
      end else if (is_armed && gap_ms != '0) begin
         for (c = 0; c < CHANNELS; c++) begin
            // 16-bit wrapped difference is already the signed delta
            step[c] = snap.enc_count[c] - held_raw[c];
            wide = {sum_total[c][TOTAL_BITS-1], sum_total[c]}
                 + {{(TOTAL_BITS-COUNT_BITS+1){step[c][COUNT_BITS-1]}}, step[c]};
            if (wide[TOTAL_BITS] != wide[TOTAL_BITS-1]) spills = 1'b1;
            next_sum[c] = wide[TOTAL_BITS-1:0];
         end
         if (spills) begin
            is_tripped = 1'b1;
            is_fresh   = 1'b0;
         end else begin
            held_raw   = snap.enc_count;
            held_delta = step;
            sum_total  = next_sum;
            stamp_ms   = snap.now_ms;
            span_ms    = gap_ms;
            is_fresh   = 1'b1;
            res.accepted = 1'b1;
         end
      end
      res.delta        = held_delta;
      res.total        = sum_total;
      res.period_ms    = span_ms;
      res.fresh_sample = is_fresh;
      res.range_error  = is_tripped;
      return res;
   endfunction

   task automatic check_field(input string what, input logic [TOTAL_BITS-1:0] want,
                              input logic [TOTAL_BITS-1:0] got);
      if (want !== got) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      ecacc_item_type   snap;
      ecacc_result_type want;
      ecacc_result_type got;
      int               c;
      if (reset) begin
         held_raw   = '0;
         held_delta = '0;
         sum_total  = '0;
         stamp_ms   = '0;
         span_ms    = '0;
         is_armed   = 1'b0;
         is_fresh   = 1'b0;
         is_tripped = 1'b0;
         expected_snapshots.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.accepted     = rsp_tuser[0];
            got.delta        = rsp_tdata[RSP_TOTAL_LSB-1:0];
            got.total        = rsp_tdata[RSP_INTERVAL_LSB-1:RSP_TOTAL_LSB];
            got.period_ms    = rsp_tdata[RSP_INTERVAL_LSB +: TIME_BITS];
            got.fresh_sample = rsp_tdata[RSP_VALID_BIT];
            got.range_error  = rsp_tdata[RSP_ERROR_BIT];
            if (expected_snapshots.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: result item with none expected, expected nothing got %h",
                           $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_snapshots.pop_front();
               check_field("accepted", TOTAL_BITS'(want.accepted),
                           TOTAL_BITS'(got.accepted));
               for (c = 0; c < CHANNELS; c++) begin
                  check_field($sformatf("delta[%0d]", c), TOTAL_BITS'(want.delta[c]),
                              TOTAL_BITS'(got.delta[c]));
                  check_field($sformatf("total[%0d]", c), want.total[c], got.total[c]);
               end
               check_field("period_ms", want.period_ms, got.period_ms);
               check_field("fresh_sample", TOTAL_BITS'(want.fresh_sample),
                           TOTAL_BITS'(got.fresh_sample));
               check_field("range_error", TOTAL_BITS'(want.range_error),
                           TOTAL_BITS'(got.range_error));
            end
         end
         if (req_tvalid && req_tready) begin
            snap.kind      = ecacc_kind_type'(req_tuser[0]);
            snap.now_ms    = req_tdata[TIME_BITS-1:0];
            snap.enc_count = req_tdata[REQ_RAW_LSB +: COUNT_BITS*CHANNELS];
            expected_snapshots.push_back(predict_snapshot(snap));
         end
      end
      failures <= mismatch_count;
      pending  <= expected_snapshots.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: drives snapshot items into encoder_count_accumulator with random idling on both
// sides, directed wrap and interval cases, and gives the verdict
// depends on ecacc_pkg, encoder_count_accumulator, encoder_count_checker

module tb_top;
   import ecacc_pkg::*;

   localparam int RANDOM_ITEMS = 1130;
   localparam int STALL_LIMIT  = 3000;
   localparam int END_CYCLES   = 8;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_CYCLES  = 300;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // now_ms, enc_count_a, enc_count_b
   logic [0:0]               req_tuser;   // req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // delta_a, delta_b, total_a, total_b,
                                          // period_ms, fresh_sample, range_error, zeros
   logic [0:0]               rsp_tuser;   // accepted
   int                       failures;
   int                       pending;

   // counts the stimulus believes the block holds
   logic [CHANNELS-1:0][COUNT_BITS-1:0] track_raw;
   logic [TIME_BITS-1:0]                track_time;
   logic                                calm = 1'b0;

   encoder_count_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   encoder_count_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_item(input ecacc_kind_type kind, input logic [TIME_BITS-1:0] now,
                            input logic [CHANNELS-1:0][COUNT_BITS-1:0] raws);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {raws, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic start_run(input logic [TIME_BITS-1:0] now, input int count_a, input int count_b);
      int c;
      track_time = now;
      for (c = 0; c < CHANNELS; c++) begin
         if (c == 0)      track_raw[c] = count_a[COUNT_BITS-1:0];
         else if (c == 1) track_raw[c] = count_b[COUNT_BITS-1:0];
         else             track_raw[c] = COUNT_BITS'($urandom_range(0, 65535));
      end
      send_item(REQ_INIT, track_time, track_raw);
   endtask

   task automatic send_update(input logic [TIME_BITS-1:0] dt, input int step_a, input int step_b);
      int c;
      track_time = track_time + dt;
      for (c = 0; c < CHANNELS; c++) begin
         if (c == 0)      track_raw[c] = track_raw[c] + step_a[COUNT_BITS-1:0];
         else if (c == 1) track_raw[c] = track_raw[c] + step_b[COUNT_BITS-1:0];
         else             track_raw[c] = track_raw[c] + COUNT_BITS'($urandom_range(0, 65535));
      end
      send_item(REQ_UPDATE, track_time, track_raw);
   endtask

   // sender stops until every result item has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // receiver side: random stalls, one long hold-off to back up the pipe
   initial begin : rsp_side
      int gap;
      int seen;
      seen = 0;
      rsp_tready <= 1'b0;
      repeat (3) @(posedge clock);
      forever begin
         if (seen == HOLD_AT) gap = HOLD_CYCLES;
         else                 gap = calm ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         seen++;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : req_side
      int n;
      int pick;
      int step_a;
      int step_b;
      logic [TIME_BITS-1:0] dt;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      track_raw  = '0;
      track_time = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // update before any init is dropped
      send_item(REQ_UPDATE, 32'h1234_5678, {CHANNELS{16'h8001}});
      start_run(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_update('0, 1, 1);                 // no time passed, ignored
      send_update(1, 32767, -32768);         // timestamp wraps to zero
      send_update(32'hFFFF_FFFF, 0, 0);      // longest interval
      send_update(5, -1, 1);
      send_update(7, -32768, 32767);
      send_update(3, 32767, 32767);
      start_run('0, 0, 0);
      send_update('0, 5, 5);
      send_update(32'h8000_0000, 1, -1);
      start_run(32'h5555_5555, 16'h5555, 16'hAAAA);
      start_run(32'hAAAA_AAAA, 16'hAAAA, 16'h5555);
      send_update(32'h5555_5555, 21845, -21846);
      send_update(32'h0000_FFFF, 12345, -12345);
      send_update(2, -32768, -32768);
      drain;

      start_run($urandom, $urandom_range(0, 65535), $urandom_range(0, 65535));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n % 200) >= 170;
         if (n == 600) drain;
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            step_a = $urandom_range(0, 65535) - 32768;
            step_b = $urandom_range(0, 65535) - 32768;
         end else begin
            step_a = $urandom_range(0, 400) - 200;
            step_b = $urandom_range(0, 400) - 200;
         end
         if (pick < 4) begin
            start_run($urandom, $urandom_range(0, 65535), $urandom_range(0, 65535));
         end else if (pick < 9) begin
            send_update('0, step_a, step_b);
         end else begin
            dt = (pick < 20) ? $urandom : $urandom_range(1, 1000);
            send_update(dt, step_a, step_b);
         end
      end

      drain;
      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
